// ===== rtl/mrmt_pkg.sv =====
// Shared defaults and command and status codes for the round-robin MRU table.
package mrmt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int ID_WIDTH_DEFAULT    = 16;
  localparam int FLAG_WIDTH_DEFAULT  = 32;

  localparam int COMMAND_WIDTH = 3;
  localparam int STATUS_WIDTH  = 2;

  typedef enum logic [COMMAND_WIDTH-1:0] {
    CMD_ADD     = 3'd0,
    CMD_QUERY   = 3'd1,
    CMD_PICK    = 3'd2,
    CMD_OR      = 3'd3,
    CMD_ADVANCE = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_PRESENT   = 2'd3
  } status_t;

endpackage

// ===== rtl/mrmt_mem.sv =====
// Entry store: one write port and one read port with registered read data.
module mrmt_mem #(
  parameter int DEPTH      = mrmt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int DATA_WIDTH = mrmt_pkg::ID_WIDTH_DEFAULT + mrmt_pkg::FLAG_WIDTH_DEFAULT,
  parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_WIDTH-1:0] waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [ADDR_WIDTH-1:0] raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/masked_round_robin_mru_table_top.sv =====
// Top level of the round-robin MRU table: command sequencer around the entry store.
//
//   Channel   Handshake          Ports
//   command   start, busy        command, entry_id, mask_bits
//   result    done (one cycle)   status, result_id, result_flags, result_position, entry_count
//
// A command is taken when start is high and busy is low. How long a command takes is set by
// the single read port of the entry store, which serves one entry per cycle during the search
// and during the move of a picked entry.
// Reset clears the count and the position; the store itself needs no clearing pass.
// The result is shown for one cycle and cannot stall.
module masked_round_robin_mru_table_top #(
  parameter int TABLE_DEPTH = mrmt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int ID_WIDTH    = mrmt_pkg::ID_WIDTH_DEFAULT,
  parameter int FLAG_WIDTH  = mrmt_pkg::FLAG_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mrmt_pkg::COMMAND_WIDTH-1:0]    command,
  input  logic [ID_WIDTH-1:0]                   entry_id,
  input  logic [FLAG_WIDTH-1:0]                 mask_bits,
  output logic                                  done,
  output logic [mrmt_pkg::STATUS_WIDTH-1:0]     status,
  output logic [ID_WIDTH-1:0]                   result_id,
  output logic [FLAG_WIDTH-1:0]                 result_flags,
  output logic [$clog2(TABLE_DEPTH)-1:0]        result_position,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = ID_WIDTH + FLAG_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DRAIN,
    S_PLACE,
    S_ADD_WR,
    S_ADV
  } state_t;

  state_t            state;
  mrmt_pkg::cmd_t    cmd;
  mrmt_pkg::status_t status_q;
  logic [ID_WIDTH-1:0]   key_id;
  logic [FLAG_WIDTH-1:0] key_mask;
  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic [CW-1:0] j;
  logic [AW-1:0] addr;
  logic          infl;
  logic [AW-1:0] infl_addr;
  logic [DW-1:0] tmp;
  logic [AW-1:0] sh_dst;
  logic [AW-1:0] sh_last;
  logic          sh_up;
  logic [AW-1:0] place_addr;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [DW-1:0] rdata;

  logic [ID_WIDTH-1:0]   rd_id;
  logic [FLAG_WIDTH-1:0] rd_flags;
  logic [CW-1:0] pos_inc;
  logic [AW-1:0] nxt_pos;
  logic [CW-1:0] addr_inc;
  logic [AW-1:0] addr_next;
  logic          id_match;
  logic          flag_match;
  logic          hit;

  assign rd_id      = rdata[DW-1:FLAG_WIDTH];
  assign rd_flags   = rdata[FLAG_WIDTH-1:0];
  assign pos_inc    = CW'(pos) + 1'b1;
  assign nxt_pos    = (pos_inc >= count) ? '0 : pos_inc[AW-1:0];
  assign addr_inc   = CW'(addr) + 1'b1;
  assign addr_next  = (addr_inc >= count) ? '0 : addr_inc[AW-1:0];
  assign id_match   = (rd_id == key_id);
  assign flag_match = ((rd_flags & key_mask) == key_mask);
  assign hit        = infl && ((cmd == mrmt_pkg::CMD_PICK) ? flag_match :
                               (((cmd == mrmt_pkg::CMD_ADD) || (cmd == mrmt_pkg::CMD_QUERY))
                                && id_match));

  assign busy            = (state != S_IDLE);
  assign status          = status_q;
  assign result_position = pos;
  assign entry_count     = count;

  mrmt_mem #(
    .DEPTH      (TABLE_DEPTH),
    .DATA_WIDTH (DW),
    .ADDR_WIDTH (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    raddr = addr;
    we    = 1'b0;
    waddr = infl_addr;
    wdata = rdata;
    unique case (state)
      S_IDLE: begin
        raddr = nxt_pos;
      end
      S_SCAN: begin
        if (infl && (cmd == mrmt_pkg::CMD_OR)) begin
          we    = 1'b1;
          wdata = {rd_id, rd_flags | key_mask};
        end
      end
      S_SHIFT: begin
        raddr = sh_up ? (sh_dst - 1'b1) : (sh_dst + 1'b1);
        we    = infl;
      end
      S_DRAIN: begin
        we = infl;
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = place_addr;
        wdata = tmp;
      end
      S_ADD_WR: begin
        we    = 1'b1;
        waddr = count[AW-1:0];
        wdata = {key_id, key_mask};
      end
      S_ADV: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pos   <= '0;
      done  <= 1'b0;
      infl  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd          <= mrmt_pkg::cmd_t'(command);
            key_id       <= entry_id;
            key_mask     <= mask_bits;
            j            <= '0;
            addr         <= '0;
            infl         <= 1'b0;
            status_q     <= mrmt_pkg::ST_OK;
            result_id    <= '0;
            result_flags <= '0;
            unique case (mrmt_pkg::cmd_t'(command))
              mrmt_pkg::CMD_ADD: begin
                state <= (count == '0) ? S_ADD_WR : S_SCAN;
              end
              mrmt_pkg::CMD_QUERY, mrmt_pkg::CMD_PICK, mrmt_pkg::CMD_ADVANCE: begin
                if (count == '0) begin
                  status_q <= mrmt_pkg::ST_NOT_FOUND;
                  done     <= 1'b1;
                end else if (mrmt_pkg::cmd_t'(command) == mrmt_pkg::CMD_ADVANCE) begin
                  pos   <= nxt_pos;
                  state <= S_ADV;
                end else begin
                  if (mrmt_pkg::cmd_t'(command) == mrmt_pkg::CMD_PICK) begin
                    addr <= nxt_pos;
                  end
                  state <= S_SCAN;
                end
              end
              mrmt_pkg::CMD_OR: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (j != count) begin
            addr      <= addr_next;
            j         <= j + 1'b1;
            infl      <= 1'b1;
            infl_addr <= addr;
          end else begin
            infl <= 1'b0;
          end
          priority if (hit) begin
            infl <= 1'b0;
            unique case (cmd)
              mrmt_pkg::CMD_ADD: begin
                status_q <= mrmt_pkg::ST_PRESENT;
                done     <= 1'b1;
                state    <= S_IDLE;
              end
              mrmt_pkg::CMD_PICK: begin
                result_id    <= rd_id;
                result_flags <= rd_flags;
                tmp          <= rdata;
                priority if (infl_addr == pos) begin
                  done  <= 1'b1;
                  state <= S_IDLE;
                end else if (infl_addr == nxt_pos) begin
                  pos   <= infl_addr;
                  done  <= 1'b1;
                  state <= S_IDLE;
                end else if (infl_addr > pos) begin
                  sh_up      <= 1'b1;
                  sh_dst     <= infl_addr;
                  sh_last    <= pos + AW'(2);
                  place_addr <= pos + 1'b1;
                  pos        <= pos + 1'b1;
                  state      <= S_SHIFT;
                end else begin
                  sh_up      <= 1'b0;
                  sh_dst     <= infl_addr;
                  sh_last    <= pos - 1'b1;
                  place_addr <= pos;
                  state      <= S_SHIFT;
                end
              end
              default: begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end else if (!infl && (j == count)) begin
            unique case (cmd)
              mrmt_pkg::CMD_ADD: begin
                if (count == CW'(TABLE_DEPTH)) begin
                  status_q <= mrmt_pkg::ST_FULL;
                  done     <= 1'b1;
                  state    <= S_IDLE;
                end else begin
                  state <= S_ADD_WR;
                end
              end
              mrmt_pkg::CMD_QUERY, mrmt_pkg::CMD_PICK: begin
                status_q <= mrmt_pkg::ST_NOT_FOUND;
                done     <= 1'b1;
                state    <= S_IDLE;
              end
              default: begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end else begin
            state <= S_SCAN;
          end
        end
        S_SHIFT: begin
          infl      <= 1'b1;
          infl_addr <= sh_dst;
          if (sh_dst == sh_last) begin
            state <= S_DRAIN;
          end else begin
            sh_dst <= sh_up ? (sh_dst - 1'b1) : (sh_dst + 1'b1);
          end
        end
        S_DRAIN: begin
          infl  <= 1'b0;
          state <= S_PLACE;
        end
        S_PLACE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_ADD_WR: begin
          count <= count + 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_ADV: begin
          result_id    <= rd_id;
          result_flags <= rd_flags;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule
